// ===== hw/rtl/stt_pkg.sv =====
// Shared types, token codes, keyword table and helper functions for the tokenizer.
`timescale 1ns / 1ps
package stt_pkg;

	localparam int POS_W       = 24;
	localparam int KW_MAX_LEN  = 7;
	localparam int KW_BITS     = 8 * KW_MAX_LEN;
	localparam int NLEN_W      = $clog2(KW_MAX_LEN + 2);
	localparam int KW_COUNT    = 19;
	localparam int MAX_TOK     = 4;
	localparam int TIDX_W      = $clog2(MAX_TOK);
	localparam int TCNT_W      = $clog2(MAX_TOK + 1);
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};
	localparam logic [63:0]      MANT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	// (MANT_MAX - d) / 10 for d <= 7 and for d > 7
	localparam logic [63:0]      THR_LO   = 64'd922337203685477580;
	localparam logic [63:0]      THR_HI   = 64'd922337203685477579;

	typedef logic [5:0] kind_t;

	// Token kinds
	localparam kind_t K_LPAREN = 6'd0,  K_RPAREN = 6'd1,  K_LBRACE = 6'd2,  K_RBRACE = 6'd3;
	localparam kind_t K_LBRACK = 6'd4,  K_RBRACK = 6'd5,  K_COMMA  = 6'd6,  K_COLON  = 6'd7;
	localparam kind_t K_TILDE  = 6'd8,  K_CARET  = 6'd9,  K_PLUS   = 6'd10, K_INC    = 6'd11;
	localparam kind_t K_PLUSEQ = 6'd12, K_MINUS  = 6'd13, K_DEC    = 6'd14, K_MINUSEQ = 6'd15;
	localparam kind_t K_STAR   = 6'd16, K_STAREQ = 6'd17, K_SLASH  = 6'd18, K_SLASHEQ = 6'd19;
	localparam kind_t K_PCT    = 6'd20, K_PCTEQ  = 6'd21, K_BANG   = 6'd22, K_NE     = 6'd23;
	localparam kind_t K_ASSIGN = 6'd24, K_EQ     = 6'd25, K_LT     = 6'd26, K_LE     = 6'd27;
	localparam kind_t K_SHL    = 6'd28, K_GT     = 6'd29, K_GE     = 6'd30, K_SHR    = 6'd31;
	localparam kind_t K_LAND   = 6'd32, K_AMP    = 6'd33, K_LOR    = 6'd34, K_PIPE   = 6'd35;
	localparam kind_t K_NUMBER = 6'd36, K_STRING = 6'd37, K_INTERP = 6'd38, K_IDENT  = 6'd39;
	localparam kind_t K_KW0    = 6'd40, K_EOF    = 6'd59, K_ERRCHAR = 6'd60, K_ERRSTR = 6'd61;

	typedef enum logic [3:0] {
		M_IDLE, M_OP, M_IDENT, M_INT, M_DOT, M_FRAC, M_STR, M_COMMENT
	} mode_t;

	typedef struct packed {
		kind_t              kind;
		logic [POS_W-1:0]   start;
		logic [POS_W-1:0]   len;
		logic [POS_W-1:0]   line;
		logic [63:0]        mant;
		logic [4:0]         frac;
		logic               isf;
	} tok_t;

	// All tokens caused by one source byte
	typedef struct packed {
		tok_t [MAX_TOK-1:0] tok;
		logic [TCNT_W-1:0]  cnt;
	} bundle_t;

	// Keywords, right-justified, first character in the high byte
	localparam logic [KW_BITS-1:0] KW_TXT [KW_COUNT] = '{
		"fr", "say", "lowkey", "midkey", "highkey", "goon", "vibe", "send",
		"ongod", "cap", "nah", "skip", "mog", "edge", "simp", "stan", "ghost",
		"yeet", "caught"
	};
	localparam logic [NLEN_W-1:0] KW_LEN [KW_COUNT] = '{
		4'd2, 4'd3, 4'd6, 4'd6, 4'd7, 4'd4, 4'd4, 4'd4, 4'd5, 4'd3,
		4'd3, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4, 4'd5, 4'd4, 4'd6
	};

	function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
		return (v == POS_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
	endfunction

	function automatic logic is_op_char(input logic [7:0] c);
		return (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "%") ||
			(c == "!") || (c == "=") || (c == "<") || (c == ">") || (c == "&") ||
			(c == "|");
	endfunction

	// {valid, kind} for characters that are a token on their own
	function automatic logic [6:0] one_char(input logic [7:0] c);
		logic [6:0] r;
		r = '0;
		case (c)
			"(": r = {1'b1, K_LPAREN};
			")": r = {1'b1, K_RPAREN};
			"{": r = {1'b1, K_LBRACE};
			"}": r = {1'b1, K_RBRACE};
			"[": r = {1'b1, K_LBRACK};
			"]": r = {1'b1, K_RBRACK};
			",": r = {1'b1, K_COMMA};
			":": r = {1'b1, K_COLON};
			"~": r = {1'b1, K_TILDE};
			"^": r = {1'b1, K_CARET};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic kind_t op_single(input logic [7:0] p);
		kind_t k;
		case (p)
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"*": k = K_STAR;
			"/": k = K_SLASH;
			"%": k = K_PCT;
			"!": k = K_BANG;
			"=": k = K_ASSIGN;
			"<": k = K_LT;
			">": k = K_GT;
			"&": k = K_AMP;
			default: k = K_PIPE;
		endcase
		return k;
	endfunction

	// {valid, kind} for a two-character operator
	function automatic logic [6:0] op_double(input logic [7:0] p, input logic [7:0] c);
		logic [6:0] r;
		r = '0;
		case (p)
			"+": r = (c == "+") ? {1'b1, K_INC} : (c == "=") ? {1'b1, K_PLUSEQ} : 7'd0;
			"-": r = (c == "-") ? {1'b1, K_DEC} : (c == "=") ? {1'b1, K_MINUSEQ} : 7'd0;
			"*": r = (c == "=") ? {1'b1, K_STAREQ} : 7'd0;
			"/": r = (c == "=") ? {1'b1, K_SLASHEQ} : 7'd0;
			"%": r = (c == "=") ? {1'b1, K_PCTEQ} : 7'd0;
			"!": r = (c == "=") ? {1'b1, K_NE} : 7'd0;
			"=": r = (c == "=") ? {1'b1, K_EQ} : 7'd0;
			"<": r = (c == "<") ? {1'b1, K_SHL} : (c == "=") ? {1'b1, K_LE} : 7'd0;
			">": r = (c == ">") ? {1'b1, K_SHR} : (c == "=") ? {1'b1, K_GE} : 7'd0;
			"&": r = (c == "&") ? {1'b1, K_LAND} : 7'd0;
			default: r = (c == "|") ? {1'b1, K_LOR} : 7'd0;
		endcase
		return r;
	endfunction

	// Parallel keyword compare
	function automatic kind_t kw_kind(input logic [KW_BITS-1:0] buf_v,
		input logic [NLEN_W-1:0] len);
		kind_t k;
		k = K_IDENT;
		for (int i = 0; i < KW_COUNT; i++) begin
			if ((len == KW_LEN[i]) && (buf_v == KW_TXT[i])) k = K_KW0 + kind_t'(i);
		end
		return k;
	endfunction

	function automatic tok_t mk_tok(input kind_t kind, input logic [POS_W-1:0] s,
		input logic [POS_W-1:0] e, input logic [POS_W-1:0] line,
		input logic [63:0] mant, input logic [4:0] frac, input logic isf);
		tok_t t;
		t.kind  = kind;
		t.start = s;
		t.len   = (e >= s) ? e - s : '0;
		t.line  = line;
		t.mant  = mant;
		t.frac  = frac;
		t.isf   = isf;
		return t;
	endfunction

endpackage

// ===== hw/rtl/stt_front.sv =====
// Scanner front end: takes one byte per beat, keeps scan state, builds the token bundle.
`timescale 1ns / 1ps
module stt_front import stt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  ch,
	input  logic        is_last,
	output bundle_t     bnd
);

	mode_t                mode_q, n_mode;
	logic [7:0]           pend_q, n_pend;
	logic [POS_W-1:0]     tstart_q, n_tstart;
	logic [POS_W-1:0]     pos_q;
	logic [POS_W-1:0]     line_q, n_line;
	logic [63:0]          acc_q, n_acc;
	logic [4:0]           frac_q, n_frac;
	logic [KW_BITS-1:0]   nbuf_q, n_nbuf;
	logic [NLEN_W-1:0]    nlen_q, n_nlen;
	logic                 obrace_q, n_obrace;
	logic                 interp_q, n_interp;

	logic [POS_W-1:0]     p, e, dp_step, dp_last;
	logic                 dig, alp, do_idle;
	logic [6:0]           opd, one;
	logic [3:0]           dval;
	logic [63:0]          acc_step;

	assign p       = pos_q;
	assign e       = sat_inc(pos_q);
	assign dp_step = (p != '0) ? p - 1'b1 : '0;
	assign dp_last = (e != '0) ? e - 1'b1 : '0;
	assign dig     = is_digit(ch);
	assign alp     = is_alpha(ch);
	assign opd     = op_double(pend_q, ch);
	assign one     = one_char(ch);
	assign dval    = 4'(ch - "0");

	// Saturating decimal digit accumulate
	assign acc_step = (acc_q > ((dval > 4'd7) ? THR_HI : THR_LO)) ? MANT_MAX :
		(acc_q << 3) + (acc_q << 1) + {60'd0, dval};

	// Byte ends the current token and gets scanned from idle
	always_comb begin
		unique case (mode_q)
			M_OP:      do_idle = !opd[6];
			M_IDENT:   do_idle = !(alp || dig);
			M_INT:     do_idle = !dig && (ch != ".");
			M_DOT:     do_idle = !dig;
			M_FRAC:    do_idle = !dig;
			M_STR:     do_idle = 1'b0;
			M_COMMENT: do_idle = (ch == "\n");
			default:   do_idle = 1'b1;
		endcase
	end

	// Next state
	always_comb begin
		n_mode   = mode_q;
		n_pend   = pend_q;
		n_tstart = tstart_q;
		n_line   = line_q;
		n_acc    = acc_q;
		n_frac   = frac_q;
		n_nbuf   = nbuf_q;
		n_nlen   = nlen_q;
		n_obrace = obrace_q;
		n_interp = interp_q;
		unique case (mode_q)
			M_OP: if (opd[6]) n_mode = M_IDLE;
			M_IDENT: begin
				if (alp || dig) begin
					if (nlen_q < NLEN_W'(KW_MAX_LEN))
						n_nbuf = {nbuf_q[KW_BITS-9:0], ch};
					if (nlen_q <= NLEN_W'(KW_MAX_LEN)) n_nlen = nlen_q + 1'b1;
				end
			end
			M_INT: begin
				if (dig) n_acc = acc_step;
				else if (ch == ".") n_mode = M_DOT;
			end
			M_DOT: begin
				if (dig) begin
					n_acc  = acc_step;
					n_frac = 5'd1;
					n_mode = M_FRAC;
				end
			end
			M_FRAC: begin
				if (dig) begin
					n_acc = acc_step;
					if (frac_q != 5'd31) n_frac = frac_q + 1'b1;
				end
			end
			M_STR: begin
				if (ch == "\"") n_mode = M_IDLE;
				else begin
					if (ch == "\n") n_line = sat_inc(line_q);
					if (ch == "{") n_obrace = 1'b1;
					if ((ch == "}") && obrace_q) n_interp = 1'b1;
				end
			end
			default: ;
		endcase
		if (do_idle) begin
			n_mode = M_IDLE;
			if (is_op_char(ch)) begin
				n_mode   = M_OP;
				n_pend   = ch;
				n_tstart = p;
			end else if (ch == "#") begin
				n_mode = M_COMMENT;
			end else if (ch == "\n") begin
				n_line = sat_inc(line_q);
			end else if (ch == "\"") begin
				n_mode   = M_STR;
				n_tstart = p;
				n_obrace = 1'b0;
				n_interp = 1'b0;
			end else if (dig) begin
				n_mode   = M_INT;
				n_tstart = p;
				n_acc    = {60'd0, dval};
				n_frac   = 5'd0;
			end else if (alp) begin
				n_mode   = M_IDENT;
				n_tstart = p;
				n_nbuf   = {{(KW_BITS-8){1'b0}}, ch};
				n_nlen   = NLEN_W'(1);
			end
		end
	end

	// Token bundle for this byte
	always_comb begin
		logic [TCNT_W-1:0] n;
		n   = '0;
		bnd = '0;
		unique case (mode_q)
			M_OP: begin
				if (opd[6]) bnd.tok[n[TIDX_W-1:0]] = mk_tok(opd[5:0], tstart_q, e, line_q,
					'0, '0, 1'b0);
				else bnd.tok[n[TIDX_W-1:0]] = mk_tok(op_single(pend_q), tstart_q, p, line_q,
					'0, '0, 1'b0);
				n = n + 1'b1;
			end
			M_IDENT: begin
				if (do_idle) begin
					bnd.tok[n[TIDX_W-1:0]] = mk_tok(kw_kind(nbuf_q, nlen_q), tstart_q, p,
						line_q, '0, '0, 1'b0);
					n = n + 1'b1;
				end
			end
			M_INT: begin
				if (do_idle) begin
					bnd.tok[n[TIDX_W-1:0]] = mk_tok(K_NUMBER, tstart_q, p, line_q, acc_q,
						'0, 1'b0);
					n = n + 1'b1;
				end
			end
			M_DOT: begin
				if (do_idle) begin
					bnd.tok[n[TIDX_W-1:0]] = mk_tok(K_NUMBER, tstart_q, dp_step, line_q,
						acc_q, '0, 1'b0);
					n = n + 1'b1;
					bnd.tok[n[TIDX_W-1:0]] = mk_tok(K_ERRCHAR, dp_step, p, line_q, '0, '0,
						1'b0);
					n = n + 1'b1;
				end
			end
			M_FRAC: begin
				if (do_idle) begin
					bnd.tok[n[TIDX_W-1:0]] = mk_tok(K_NUMBER, tstart_q, p, line_q, acc_q,
						frac_q, 1'b1);
					n = n + 1'b1;
				end
			end
			M_STR: begin
				if (ch == "\"") begin
					bnd.tok[n[TIDX_W-1:0]] = mk_tok(interp_q ? K_INTERP : K_STRING,
						tstart_q, e, line_q, '0, '0, 1'b0);
					n = n + 1'b1;
				end
			end
			default: ;
		endcase
		// Byte scanned from idle
		if (do_idle) begin
			if (one[6]) begin
				bnd.tok[n[TIDX_W-1:0]] = mk_tok(one[5:0], p, e, line_q, '0, '0, 1'b0);
				n = n + 1'b1;
			end else if (!is_op_char(ch) && (ch != "#") && (ch != " ") && (ch != "\015") &&
				(ch != "\t") && (ch != "\n") && (ch != "\"") && !dig && !alp) begin
				bnd.tok[n[TIDX_W-1:0]] = mk_tok(K_ERRCHAR, p, e, line_q, '0, '0, 1'b0);
				n = n + 1'b1;
			end
		end
		// Close pending token and add end of file
		if (is_last) begin
			unique case (n_mode)
				M_OP: begin
					bnd.tok[n[TIDX_W-1:0]] = mk_tok(op_single(n_pend), n_tstart, e, n_line,
						'0, '0, 1'b0);
					n = n + 1'b1;
				end
				M_IDENT: begin
					bnd.tok[n[TIDX_W-1:0]] = mk_tok(kw_kind(n_nbuf, n_nlen), n_tstart, e,
						n_line, '0, '0, 1'b0);
					n = n + 1'b1;
				end
				M_INT: begin
					bnd.tok[n[TIDX_W-1:0]] = mk_tok(K_NUMBER, n_tstart, e, n_line, n_acc,
						'0, 1'b0);
					n = n + 1'b1;
				end
				M_DOT: begin
					bnd.tok[n[TIDX_W-1:0]] = mk_tok(K_NUMBER, n_tstart, dp_last, n_line,
						n_acc, '0, 1'b0);
					n = n + 1'b1;
					bnd.tok[n[TIDX_W-1:0]] = mk_tok(K_ERRCHAR, dp_last, e, n_line, '0, '0,
						1'b0);
					n = n + 1'b1;
				end
				M_FRAC: begin
					bnd.tok[n[TIDX_W-1:0]] = mk_tok(K_NUMBER, n_tstart, e, n_line, n_acc,
						n_frac, 1'b1);
					n = n + 1'b1;
				end
				M_STR: begin
					bnd.tok[n[TIDX_W-1:0]] = mk_tok(K_ERRSTR, n_tstart, e, n_line, '0, '0,
						1'b0);
					n = n + 1'b1;
				end
				default: ;
			endcase
			bnd.tok[n[TIDX_W-1:0]] = mk_tok(K_EOF, e, e, n_line, '0, '0, 1'b0);
			n = n + 1'b1;
		end
		bnd.cnt = n;
	end

	// State registers; end of source returns to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pend_q   <= '0;
			tstart_q <= '0;
			pos_q    <= '0;
			line_q   <= POS_W'(1);
			acc_q    <= '0;
			frac_q   <= '0;
			nbuf_q   <= '0;
			nlen_q   <= '0;
			obrace_q <= 1'b0;
			interp_q <= 1'b0;
		end else if (accept) begin
			if (is_last) begin
				mode_q   <= M_IDLE;
				pend_q   <= '0;
				tstart_q <= '0;
				pos_q    <= '0;
				line_q   <= POS_W'(1);
				acc_q    <= '0;
				frac_q   <= '0;
				nbuf_q   <= '0;
				nlen_q   <= '0;
				obrace_q <= 1'b0;
				interp_q <= 1'b0;
			end else begin
				mode_q   <= n_mode;
				pend_q   <= n_pend;
				tstart_q <= n_tstart;
				pos_q    <= e;
				line_q   <= n_line;
				acc_q    <= n_acc;
				frac_q   <= n_frac;
				nbuf_q   <= n_nbuf;
				nlen_q   <= n_nlen;
				obrace_q <= n_obrace;
				interp_q <= n_interp;
			end
		end
	end

endmodule

// ===== hw/rtl/stt_queue.sv =====
// Short bundle queue between the scanner front end and the token drain.
`timescale 1ns / 1ps
module stt_queue import stt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t wr_data,
	input  logic    pop,
	output bundle_t head,
	output logic    full,
	output logic    empty
);

	bundle_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/stt_back.sv =====
// Token drain: walks the head bundle one token a beat into the output register.
`timescale 1ns / 1ps
module stt_back import stt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  bundle_t           head,
	input  logic              empty,
	output logic              pop,
	input  logic              tok_ready,
	output logic              tok_valid,
	output tok_t              tok,
	output logic              last_of_run
);

	logic [TIDX_W-1:0] idx_q;
	logic              load, at_end;

	assign load   = !empty && (!tok_valid || tok_ready);
	assign at_end = ({1'b0, idx_q} == TCNT_W'(head.cnt - 1'b1));
	assign pop    = load && at_end;

	// Control: output valid and position within the bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (load) begin
				tok_valid <= 1'b1;
				idx_q     <= at_end ? '0 : idx_q + 1'b1;
			end else if (tok_ready) begin
				tok_valid <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			tok         <= head.tok[idx_q];
			last_of_run <= at_end;
		end
	end

endmodule

// ===== hw/rtl/source_text_tokenizer.sv =====
// Throughput: one source byte per cycle while the bundle queue has room; one token per beat out.
// A token's bundle enters the bundle queue when its byte is accepted; the token then moves into the output register.
// A byte that causes k tokens takes k output beats; the two-entry bundle queue sets how far
// the scanner may run ahead of a stalled output.
// Reset: asynchronous, clears scan state (line 1, offset 0) and empties queue and output.
`timescale 1ns / 1ps
module source_text_tokenizer import stt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_ready,
	input  logic [7:0]        ch,
	input  logic              is_last,
	output logic              tok_valid,
	input  logic              tok_ready,
	output logic [5:0]        token_kind,
	output logic [23:0]       start_offset,
	output logic [23:0]       token_length,
	output logic [23:0]       line_number,
	output logic signed [63:0] mantissa,
	output logic [4:0]        fraction_digits,
	output logic              is_float,
	output logic              last_of_run
);

	bundle_t bnd, head;
	logic    accept, full, empty, pop;
	tok_t    tok;

	assign src_ready = !full;
	assign accept    = src_valid && src_ready;

	stt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.ch      (ch),
		.is_last (is_last),
		.bnd     (bnd)
	);

	stt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept && (bnd.cnt != '0)),
		.wr_data (bnd),
		.pop     (pop),
		.head    (head),
		.full    (full),
		.empty   (empty)
	);

	stt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.tok_ready   (tok_ready),
		.tok_valid   (tok_valid),
		.tok         (tok),
		.last_of_run (last_of_run)
	);

	assign token_kind      = tok.kind;
	assign start_offset    = tok.start;
	assign token_length    = tok.len;
	assign line_number     = tok.line;
	assign mantissa        = tok.mant;
	assign fraction_digits = tok.frac;
	assign is_float        = tok.isf;

endmodule

// ===== hw/rtl/stt_checker.sv =====
// Port-level checks for the tokenizer, bound to the top level.
`timescale 1ns / 1ps
module stt_checker import stt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_valid,
	input  logic              tok_ready,
	input  logic [5:0]        token_kind,
	input  logic [23:0]       start_offset,
	input  logic [23:0]       line_number,
	input  logic signed [63:0] mantissa,
	input  logic [4:0]        fraction_digits,
	input  logic              is_float,
	input  logic              last_of_run
);

	// Stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid && $stable(token_kind) && $stable(start_offset))
		else $error("stalled token changed");

	// End of file closes the run of results
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (token_kind == K_EOF) |-> last_of_run)
		else $error("end of file token not last of run");

	// Only numbers carry a value
	a_num_only: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (token_kind != K_NUMBER) |->
			(mantissa == 0) && (fraction_digits == 0) && !is_float)
		else $error("value on a non-number token");

	// Lines count from one
	a_line: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (line_number != 24'd0))
		else $error("line number zero");

endmodule

bind source_text_tokenizer stt_checker u_chk (.*);
